FILE: sv/wct_pkg.sv
// Shared types and constants for the wrapping counter timestamp block.
package wct_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int CYCLES_W   = 64;
    localparam int MHZ_W      = 10;
    localparam int DIVISOR_W  = 30;
    localparam int SECS_W     = 45;
    localparam int STEP_W     = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MHZ_W-1:0] CLOCK_MHZ_RESET = 10'd200;

    localparam logic [DIVISOR_W-1:0] USEC_PER_SEC  = 30'd1000000;
    localparam logic [DIVISOR_W-1:0] USEC_PER_MSEC = 30'd1000;

    // Step counts of the three divide passes; each pass skips leading
    // quotient bits that are known to be zero.
    localparam logic [STEP_W-1:0] STEPS_SEC = 6'd45;
    localparam logic [STEP_W-1:0] STEPS_MS  = 6'd10;
    localparam logic [STEP_W-1:0] STEPS_US  = 6'd10;

    // Configuration register index (byte address bit 2)
    localparam logic REG_CLOCK_MHZ = 1'b0;

    // Queued request: full wrap-extended cycle count of one time query
    typedef struct packed {
        logic                valid;
        logic [CYCLES_W-1:0] cycles;
    } q_req_t;

    typedef struct packed {
        logic [63:0] total_micros;
        logic [9:0]  micros;
        logic [9:0]  millis;
        logic [31:0] seconds;
    } result_t;

endpackage

FILE: sv/wct_front.sv
// Front end: accepts samples, runs the wrap check, queues time queries.
module wct_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [wct_pkg::SAMPLE_W-1:0] sample,
    input  logic                         req_type,
    input  logic                         q_full,
    output wct_pkg::q_req_t              q_push
);
    import wct_pkg::*;

    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [SAMPLE_W-1:0] wrap_reg, wrap_next;
    logic                accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb
    begin
        prev_next = prev_reg;
        wrap_next = wrap_reg;
        if (accept)
        begin
            prev_next = sample;
            if (sample < prev_reg)
            begin
                wrap_next = wrap_reg + 32'd1;
            end
        end
    end

    // Counter period is 2^32, so wraps * period + sample is a concatenation
    assign q_push.valid  = accept && req_type;
    assign q_push.cycles = {wrap_next, sample};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            wrap_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
            wrap_reg <= wrap_next;
        end
    end

endmodule

FILE: sv/wct_fifo.sv
// Short request queue between the front end and the divide back end.
module wct_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  wct_pkg::q_req_t push,
    input  logic            pop,
    output logic            full,
    output wct_pkg::q_req_t head
);
    import wct_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [CYCLES_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full        = (count_reg == CNT_FULL);
    assign head.valid  = (count_reg != '0);
    assign head.cycles = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.cycles;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/wct_back.sv
// Back end: bit-serial divider that turns a cycle count into time fields.
module wct_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [wct_pkg::MHZ_W-1:0] clock_mhz,
    input  wct_pkg::q_req_t           q_head,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output wct_pkg::result_t          out_data
);
    import wct_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] PH_SEC = 2'd0;
    localparam logic [1:0] PH_MS  = 2'd1;
    localparam logic [1:0] PH_US  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           phase_reg, phase_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [CYCLES_W-1:0]  quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] div_reg, div_next;
    logic [63:0]          total_reg, total_next;
    logic [SECS_W-1:0]    secs_reg, secs_next;
    logic [9:0]           ms_reg, ms_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              res_reg, res_next;

    logic [MHZ_W-1:0]     mhz_eff;
    logic [DIVISOR_W-1:0] mhz_ext;
    logic [DIVISOR_W-1:0] hz;
    logic [DIVISOR_W-1:0] hz_ms;
    logic [DIVISOR_W:0]   rem_shift;
    logic                 ge;
    logic [DIVISOR_W-1:0] r_step;
    logic [CYCLES_W-1:0]  q_step;
    logic [CYCLES_W-1:0]  secs_ext, secs_scaled;
    logic [CYCLES_W-1:0]  ms_ext, ms_scaled, us_ext;
    logic                 out_free;

    assign mhz_eff = (clock_mhz == '0) ? MHZ_W'(1) : clock_mhz;
    assign mhz_ext = {{(DIVISOR_W-MHZ_W){1'b0}}, mhz_eff};
    assign hz      = mhz_ext * USEC_PER_SEC;
    assign hz_ms   = mhz_ext * USEC_PER_MSEC;

    // 1e6 = 2^20 - 2^16 + 2^14 + 2^9 + 2^6; 1000 = 2^10 - 2^4 - 2^3
    assign secs_ext    = {{(CYCLES_W-SECS_W){1'b0}}, secs_reg};
    assign secs_scaled = (secs_ext << 20) - (secs_ext << 16) + (secs_ext << 14)
                       + (secs_ext << 9) + (secs_ext << 6);
    assign ms_ext      = {{(CYCLES_W-10){1'b0}}, ms_reg};
    assign ms_scaled   = (ms_ext << 10) - (ms_ext << 4) - (ms_ext << 3);
    assign us_ext      = {{(CYCLES_W-10){1'b0}}, quo_reg[9:0]};

    // One restoring divide step
    assign rem_shift = {rem_reg, quo_reg[CYCLES_W-1]};
    assign ge        = (rem_shift >= {1'b0, div_reg});
    assign r_step    = ge ? DIVISOR_W'(rem_shift - {1'b0, div_reg})
                          : rem_shift[DIVISOR_W-1:0];
    assign q_step    = {quo_reg[CYCLES_W-2:0], ge};

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_head.valid;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        total_next     = total_reg;
        secs_next      = secs_reg;
        ms_next        = ms_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    // seconds fit in 45 bits; the top 19 bits of the count are below 1e6
                    quo_next   = {q_head.cycles[44:0], 19'd0};
                    rem_next   = {11'd0, q_head.cycles[63:45]};
                    div_next   = hz;
                    cnt_next   = STEPS_SEC;
                    phase_next = PH_SEC;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                quo_next = q_step;
                rem_next = r_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    case (phase_reg)
                        PH_SEC:
                        begin
                            // r_step < 1000 * hz_ms, so its top 20 bits are below hz_ms
                            secs_next  = q_step[SECS_W-1:0];
                            rem_next   = {10'd0, r_step[29:10]};
                            quo_next   = {r_step[9:0], 54'd0};
                            div_next   = hz_ms;
                            cnt_next   = STEPS_MS;
                            phase_next = PH_MS;
                        end
                        PH_MS:
                        begin
                            // r_step < 1000 * mhz, so its top 20 bits are below mhz
                            ms_next    = q_step[9:0];
                            total_next = secs_scaled;
                            rem_next   = {10'd0, r_step[29:10]};
                            quo_next   = {r_step[9:0], 54'd0};
                            div_next   = mhz_ext;
                            cnt_next   = STEPS_US;
                            phase_next = PH_US;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next.total_micros = total_reg + ms_scaled + us_ext;
                    res_next.seconds      = secs_reg[31:0];
                    res_next.millis       = ms_reg;
                    res_next.micros       = quo_reg[9:0];
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        total_reg <= total_next;
        secs_reg  <= secs_next;
        ms_reg    <= ms_next;
        res_reg   <= res_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/wrapping_counter_timestamp_top.sv
// Top level of the wrapping counter timestamp block.
//
// Usage:
//   s_axis carries one request per sample of a free-running 32-bit cycle
//   counter (tdata = counter_sample, tuser = req_type). Every request runs
//   the wrap check; req_type 0 (overflow event) ends there with no result,
//   req_type 1 (time query) yields one result on m_axis.
//   m_axis tdata = seconds, millis, micros, total_micros (low bits first).
//   APB register at byte 0: clock_mhz (reset 200, 0 acts as 1 MHz); write it
//   only while no query is in flight.
// Timing:
//   The front end takes a request every cycle while the 2-entry queue has
//   room. The back end is a 1-bit-per-cycle restoring divider run three
//   times (45 steps by clock_mhz * 1e6, 10 by clock_mhz * 1000, 10 by
//   clock_mhz), and it takes the next query from the queue only after the
//   last result has moved to the output register. Overflow events end in
//   the front end.
// Reset clears the wrap count, previous sample, queue and output valid.
// A stalled m_axis holds its result; the divider still finishes the next
// query and waits, and the front end keeps accepting until the queue fills.
module wrapping_counter_timestamp_top (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] counter_sample
    input  logic         s_axis_tuser,   // [0] req_type
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata    // [31:0] seconds, [41:32] millis,
                                         // [51:42] micros, [115:52] total_micros
);
    import wct_pkg::*;

    logic [MHZ_W-1:0] clock_mhz_reg, clock_mhz_next;
    logic             cfg_write;
    q_req_t           q_push;
    q_req_t           q_head;
    logic             q_full;
    logic             q_pop;
    result_t          res;

    // ---- configuration register ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        clock_mhz_next = clock_mhz_reg;
        if (cfg_write && (paddr[2] == REG_CLOCK_MHZ))
        begin
            clock_mhz_next = pwdata[MHZ_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CLOCK_MHZ)
        begin
            prdata = {{(32-MHZ_W){1'b0}}, clock_mhz_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_mhz_reg <= CLOCK_MHZ_RESET;
        end
        else
        begin
            clock_mhz_reg <= clock_mhz_next;
        end
    end

    // ---- front end: wrap check and classification ----
    wct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .sample   (s_axis_tdata),
        .req_type (s_axis_tuser),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    // ---- query queue ----
    wct_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .full  (q_full),
        .head  (q_head)
    );

    // ---- back end: divider and output register ----
    wct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clock_mhz (clock_mhz_reg),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {4'd0, res.total_micros, res.micros, res.millis, res.seconds};

endmodule
